// File: rtl/core/btpa_pkg.sv
// ----------------------------------------------------------------------------
// btpa_pkg: shared definitions of the bit tree page allocator
// Tree geometry, command codes, sequencer state codes and the result record
// of the node step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package btpa_pkg;

	localparam int NUM_PAGES = 1024;
	// tree nodes 0 .. 2*NUM_PAGES-1, stored as sibling pairs: row r holds 2r, 2r+1
	localparam int NODE_W    = $clog2(2 * NUM_PAGES);
	localparam int NUM_ROWS  = NUM_PAGES;
	localparam int ROW_W     = $clog2(NUM_ROWS);
	localparam int PAGE_W    = 10;
	localparam int CMD_W     = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam int STATE_W = 3;
	localparam logic [STATE_W-1:0] ST_CLEAR = 3'd0;
	localparam logic [STATE_W-1:0] ST_IDLE  = 3'd1;
	localparam logic [STATE_W-1:0] ST_ROOT  = 3'd2;
	localparam logic [STATE_W-1:0] ST_DOWN  = 3'd3;
	localparam logic [STATE_W-1:0] ST_UPCLR = 3'd4;
	localparam logic [STATE_W-1:0] ST_UPSET = 3'd5;
	localparam logic [STATE_W-1:0] ST_QUERY = 3'd6;

	typedef struct packed {
		logic              finish;
		logic              ok;
		logic              alloc_done;
		logic              page_ld;
		logic [PAGE_W-1:0] page;
		logic              page_free;
		logic              wr_en;
		logic [ROW_W-1:0]  wr_addr;
		logic [1:0]        wr_data;
		logic [NODE_W-1:0] next_node;
		logic [ROW_W-1:0]  next_row;
	} step_res_t;

endpackage

`default_nettype wire

// File: rtl/core/btpa_ram.sv
// ----------------------------------------------------------------------------
// btpa_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module btpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/btpa_step.sv
// ----------------------------------------------------------------------------
// btpa_step: node step unit of the bit tree page allocator
// Given the current node and the sibling pair row just read, works out one
// step of the walk down or the climb up: the row to write back, the next
// node and row to visit, and whether the command ends here.
// ----------------------------------------------------------------------------
`default_nettype none

module btpa_step (
	input  wire logic [btpa_pkg::STATE_W-1:0] mode,
	input  wire logic [btpa_pkg::NODE_W-1:0]  node,
	input  wire logic [1:0]                   rdata,
	output btpa_pkg::step_res_t               res
);

	logic [btpa_pkg::NODE_W-1:0] child;
	logic [btpa_pkg::NODE_W-1:0] parent;
	logic [btpa_pkg::NODE_W-1:0] page_node;

	always_comb begin
		// left child when its bit is set, otherwise the right one
		child     = {node[btpa_pkg::NODE_W-2:0], ~rdata[0]};
		parent    = {1'b0, node[btpa_pkg::NODE_W-1:1]};
		page_node = child - btpa_pkg::NODE_W'(btpa_pkg::NUM_PAGES);

		res           = '0;
		res.next_node = parent;
		res.next_row  = parent[btpa_pkg::NODE_W-1:1];
		res.wr_addr   = node[btpa_pkg::NODE_W-1:1];
		res.wr_data   = rdata;

		case (mode)
			btpa_pkg::ST_ROOT: begin
				if (!rdata[1]) begin
					res.finish = 1'b1;
				end else begin
					res.next_node = btpa_pkg::NODE_W'(1);
					res.next_row  = btpa_pkg::ROW_W'(1);
				end
			end
			btpa_pkg::ST_DOWN: begin
				if (!rdata[0] && !rdata[1]) begin
					res.finish = 1'b1;
				end else if (child >= btpa_pkg::NODE_W'(btpa_pkg::NUM_PAGES)) begin
					// leaf reached: hand out the page and clear it
					res.page_ld          = 1'b1;
					res.page             = btpa_pkg::PAGE_W'(page_node);
					res.wr_en            = 1'b1;
					res.wr_addr          = node[btpa_pkg::ROW_W-1:0];
					res.wr_data[child[0]] = 1'b0;
					if (rdata[~child[0]]) begin
						res.finish     = 1'b1;
						res.ok         = 1'b1;
						res.alloc_done = 1'b1;
					end else begin
						res.next_node = node;
						res.next_row  = node[btpa_pkg::NODE_W-1:1];
					end
				end else begin
					res.next_node = child;
					res.next_row  = child[btpa_pkg::ROW_W-1:0];
				end
			end
			btpa_pkg::ST_UPCLR: begin
				res.wr_en            = 1'b1;
				res.wr_data[node[0]] = 1'b0;
				// stop at the root or where the sibling still has free pages
				if (node == btpa_pkg::NODE_W'(1) || rdata[~node[0]]) begin
					res.finish     = 1'b1;
					res.ok         = 1'b1;
					res.alloc_done = 1'b1;
				end
			end
			btpa_pkg::ST_UPSET: begin
				if (rdata[node[0]]) begin
					res.finish = 1'b1;
					res.ok     = 1'b1;
				end else begin
					res.wr_en            = 1'b1;
					res.wr_data[node[0]] = 1'b1;
					if (node == btpa_pkg::NODE_W'(1)) begin
						res.finish = 1'b1;
						res.ok     = 1'b1;
					end
				end
			end
			btpa_pkg::ST_QUERY: begin
				res.finish    = 1'b1;
				res.ok        = 1'b1;
				res.page_free = rdata[node[0]];
			end
			default: begin
				res.finish = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/bit_tree_page_allocator.sv
// ----------------------------------------------------------------------------
// bit_tree_page_allocator: page allocator over a heap-indexed bit tree
// Allocate walks down from the root and clears bits on the way back up;
// free sets bits upward from the leaf; query reads one leaf bit.
// ----------------------------------------------------------------------------
//
//  channel   signals                        transfer
//  -------   ----------------------------   ---------------------------
//  command   start, busy, cmd, page_index    start && !busy at clk edge
//  result    done, ok, page_out, page_free   done high for one cycle
//
// The tree lives in one RAM of sibling pairs, one row read and one row
// written per cycle, so the walk moves one tree level per row read. A bad
// page number or unknown command is answered straight from idle, with no
// tree walk. After reset a sweep sets every row, NUM_PAGES rows, one row a
// cycle, with busy high. The receiver cannot stall; a result is shown once.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_tree_page_allocator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [btpa_pkg::CMD_W-1:0]   cmd,
	input  wire logic [btpa_pkg::PAGE_W-1:0]  page_index,
	output logic                              done,
	output logic                              ok,
	output logic      [btpa_pkg::PAGE_W-1:0]  page_out,
	output logic                              page_free
);

	logic [btpa_pkg::STATE_W-1:0] st_q;
	logic [btpa_pkg::ROW_W-1:0]   clr_q;
	logic [btpa_pkg::NODE_W-1:0]  node_q;
	logic [btpa_pkg::PAGE_W-1:0]  page_q;
	logic                         done_q;
	logic                         ok_q;
	logic [btpa_pkg::PAGE_W-1:0]  page_out_q;
	logic                         page_free_q;

	logic                         in_range;
	logic [btpa_pkg::NODE_W-1:0]  leaf;
	logic                         ram_we;
	logic [btpa_pkg::ROW_W-1:0]   ram_waddr;
	logic [1:0]                   ram_wdata;
	logic [btpa_pkg::ROW_W-1:0]   ram_raddr;
	logic [1:0]                   ram_rdata;
	btpa_pkg::step_res_t          step;

	assign in_range = 32'(page_index) < 32'(btpa_pkg::NUM_PAGES);
	assign leaf     = btpa_pkg::NODE_W'(btpa_pkg::NUM_PAGES)
	                + btpa_pkg::NODE_W'(page_index);

	always_comb begin
		if (st_q == btpa_pkg::ST_IDLE) begin
			ram_raddr = (cmd == btpa_pkg::CMD_ALLOC) ? '0
			          : leaf[btpa_pkg::NODE_W-1:1];
		end else begin
			ram_raddr = step.next_row;
		end
		if (st_q == btpa_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 2'b11;
		end else begin
			ram_we    = step.wr_en;
			ram_waddr = step.wr_addr;
			ram_wdata = step.wr_data;
		end
	end

	btpa_ram #(
		.WIDTH (2),
		.DEPTH (btpa_pkg::NUM_ROWS)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	btpa_step u_step (
		.mode  (st_q),
		.node  (node_q),
		.rdata (ram_rdata),
		.res   (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= btpa_pkg::ST_CLEAR;
			clr_q       <= '0;
			node_q      <= '0;
			page_q      <= '0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			page_out_q  <= '0;
			page_free_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				btpa_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == btpa_pkg::ROW_W'(btpa_pkg::NUM_ROWS - 1)) begin
						st_q <= btpa_pkg::ST_IDLE;
					end
				end
				btpa_pkg::ST_IDLE: begin
					if (start) begin
						case (cmd)
							btpa_pkg::CMD_ALLOC: begin
								st_q <= btpa_pkg::ST_ROOT;
							end
							btpa_pkg::CMD_FREE, btpa_pkg::CMD_QUERY: begin
								if (in_range) begin
									node_q <= leaf;
									st_q   <= (cmd == btpa_pkg::CMD_FREE)
									        ? btpa_pkg::ST_UPSET : btpa_pkg::ST_QUERY;
								end else begin
									done_q      <= 1'b1;
									ok_q        <= 1'b0;
									page_out_q  <= '0;
									page_free_q <= 1'b0;
								end
							end
							default: begin
								// unknown command: answer with all zeros
								done_q      <= 1'b1;
								ok_q        <= 1'b0;
								page_out_q  <= '0;
								page_free_q <= 1'b0;
							end
						endcase
					end
				end
				default: begin
					if (step.finish) begin
						st_q        <= btpa_pkg::ST_IDLE;
						done_q      <= 1'b1;
						ok_q        <= step.ok;
						page_out_q  <= step.alloc_done
						             ? (step.page_ld ? step.page : page_q) : '0;
						page_free_q <= step.page_free;
					end else begin
						node_q <= step.next_node;
						if (st_q == btpa_pkg::ST_ROOT) begin
							st_q <= btpa_pkg::ST_DOWN;
						end else if (step.page_ld) begin
							// leaf cleared: climb toward the root
							st_q <= btpa_pkg::ST_UPCLR;
						end
						if (step.page_ld) begin
							page_q <= step.page;
						end
					end
				end
			endcase
		end
	end

	assign busy      = (st_q != btpa_pkg::ST_IDLE);
	assign done      = done_q;
	assign ok        = ok_q;
	assign page_out  = page_out_q;
	assign page_free = page_free_q;

	// accepted command either starts a tree walk or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither started nor answered");

	a_page_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && page_out != '0) |-> ok)
		else $error("page number given without success");

	a_free_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && page_free) |-> ok)
		else $error("page status given without success");

	a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == btpa_pkg::ST_CLEAR) |-> !done)
		else $error("result strobe during the reset sweep");

endmodule

`default_nettype wire

// File: dv/tb_bit_tree_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_tree_page_allocator: self-checking bench of the bit tree allocator
// Drives allocate, free, query and unknown commands through the start/busy
// handshake and mirrors the free-bit tree in a scoreboard. Each command's
// expected reply is worked out when the transfer happens. Each done strobe
// is compared in order against those replies.
// ----------------------------------------------------------------------------

module tb_bit_tree_page_allocator;

	// no package name for the unused opcode
	localparam logic [btpa_pkg::CMD_W-1:0] CMD_BAD = 2'd3;
	localparam int TREE_NODES = 2 * btpa_pkg::NUM_PAGES;

	typedef struct {
		logic                        ok;
		logic [btpa_pkg::PAGE_W-1:0] page;
		logic                        pfree;
	} alloc_reply_t;

	class page_tree_scoreboard;
		bit           free_bits [TREE_NODES];
		alloc_reply_t expected_replies [$];
		int           errors;
		int           alloc_fails;

		function new();
			foreach (free_bits[i]) free_bits[i] = 1'b1;
			errors      = 0;
			alloc_fails = 0;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		// pick a page that is currently handed out, -1 when none is
		function int pick_used();
			int unsigned base;
			int unsigned k;
			int unsigned pg;
			base = $urandom_range(btpa_pkg::NUM_PAGES - 1);
			for (k = 0; k < btpa_pkg::NUM_PAGES; k++) begin
				pg = (base + k) % btpa_pkg::NUM_PAGES;
				if (!free_bits[btpa_pkg::NUM_PAGES + pg]) return pg;
			end
			return -1;
		endfunction

		function void note_command(logic [btpa_pkg::CMD_W-1:0] c,
		                           logic [btpa_pkg::PAGE_W-1:0] p);
			alloc_reply_t r;
			int unsigned  node;
			bit           walking;
			bit           sib;
			r = '{1'b0, '0, 1'b0};
			case (c)
				btpa_pkg::CMD_ALLOC: begin
					node    = 1;
					walking = 1'b1;
					while (walking && node < TREE_NODES) begin
						if (free_bits[node]) begin
							if (node >= btpa_pkg::NUM_PAGES) begin
								r.ok    = 1'b1;
								r.page  = btpa_pkg::PAGE_W'(node - btpa_pkg::NUM_PAGES);
								walking = 1'b0;
								// clear upward until the sibling still has a free page
								sib = 1'b0;
								while (!sib && node != 0) begin
									free_bits[node] = 1'b0;
									if (node == 1) begin
										node = 0;
									end else begin
										sib  = free_bits[node ^ 1];
										node = node >> 1;
									end
								end
							end else begin
								node = node << 1;
							end
						end else if (node[0]) begin
							walking = 1'b0;
						end else begin
							node = node + 1;
						end
					end
					if (!r.ok) alloc_fails++;
				end
				btpa_pkg::CMD_FREE: begin
					if (p < btpa_pkg::NUM_PAGES) begin
						node = btpa_pkg::NUM_PAGES + p;
						while (node != 0 && !free_bits[node]) begin
							free_bits[node] = 1'b1;
							node = node >> 1;
						end
						r.ok = 1'b1;
					end
				end
				btpa_pkg::CMD_QUERY: begin
					if (p < btpa_pkg::NUM_PAGES) begin
						r.pfree = free_bits[btpa_pkg::NUM_PAGES + p];
						r.ok    = 1'b1;
					end
				end
				default: ;
			endcase
			expected_replies.push_back(r);
		endfunction

		function void check_reply(logic a_ok, logic [btpa_pkg::PAGE_W-1:0] a_page,
		                          logic a_free);
			alloc_reply_t e;
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: ok=%0b page_out=%0d page_free=%0b",
					$time, a_ok, a_page, a_free);
				return;
			end
			e = expected_replies.pop_front();
			if (a_ok !== e.ok || a_page !== e.page || a_free !== e.pfree) begin
				errors++;
				$display("%0t: mismatch: expected ok=%0b page_out=%0d page_free=%0b,",
					$time, e.ok, e.page, e.pfree,
					" actual ok=%0b page_out=%0d page_free=%0b",
					a_ok, a_page, a_free);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [btpa_pkg::CMD_W-1:0]  cmd;
	logic [btpa_pkg::PAGE_W-1:0] page_index;
	logic                        done;
	logic                        ok;
	logic [btpa_pkg::PAGE_W-1:0] page_out;
	logic                        page_free;

	page_tree_scoreboard sb;
	bit                  idle_on;

	bit_tree_page_allocator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.page_index (page_index),
		.done       (done),
		.ok         (ok),
		.page_out   (page_out),
		.page_free  (page_free)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_reply(ok, page_out, page_free);
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// hold start until the transfer, then note it and maybe idle a while
	task automatic send_cmd(input logic [btpa_pkg::CMD_W-1:0] c,
	                        input logic [btpa_pkg::PAGE_W-1:0] p);
		start      <= 1'b1;
		cmd        <= c;
		page_index <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(c, p);
		if (idle_on) begin
			while ($urandom_range(99) < 32) begin
				start      <= 1'b0;
				cmd        <= btpa_pkg::CMD_W'($urandom);
				page_index <= btpa_pkg::PAGE_W'($urandom);
				@(posedge clk);
			end
		end
	endtask

	task automatic send_random(input int alloc_pct, input int free_pct);
		int roll;
		int pg;
		roll = $urandom_range(99);
		if (roll < alloc_pct) begin
			send_cmd(btpa_pkg::CMD_ALLOC, btpa_pkg::PAGE_W'($urandom));
		end else if (roll < alloc_pct + free_pct) begin
			pg = sb.pick_used();
			if (pg < 0 || $urandom_range(3) == 0) pg = $urandom_range(btpa_pkg::NUM_PAGES - 1);
			send_cmd(btpa_pkg::CMD_FREE, btpa_pkg::PAGE_W'(pg));
		end else if ($urandom_range(5) == 0) begin
			send_cmd(CMD_BAD, btpa_pkg::PAGE_W'($urandom));
		end else begin
			send_cmd(btpa_pkg::CMD_QUERY, btpa_pkg::PAGE_W'($urandom));
		end
	endtask

	// drop start and wait for every outstanding reply
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		int guard;
		sb         = new();
		idle_on    = 1'b1;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = btpa_pkg::CMD_ALLOC;
		page_index = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: edges of page numbers, every opcode, double free
		send_cmd(btpa_pkg::CMD_QUERY, 10'd0);
		send_cmd(btpa_pkg::CMD_QUERY, 10'h3FF);
		send_cmd(btpa_pkg::CMD_ALLOC, 10'h3FF);
		send_cmd(btpa_pkg::CMD_ALLOC, 10'd0);
		send_cmd(btpa_pkg::CMD_QUERY, 10'd0);
		send_cmd(btpa_pkg::CMD_FREE,  10'd0);
		send_cmd(btpa_pkg::CMD_FREE,  10'd0);
		send_cmd(btpa_pkg::CMD_ALLOC, 10'h2AA);
		send_cmd(btpa_pkg::CMD_QUERY, 10'h2AA);
		send_cmd(btpa_pkg::CMD_FREE,  10'h3FF);
		send_cmd(btpa_pkg::CMD_QUERY, 10'h3FF);
		send_cmd(CMD_BAD,             10'h3FF);
		send_cmd(CMD_BAD,             10'd0);
		send_cmd(btpa_pkg::CMD_FREE,  10'd1);
		send_cmd(btpa_pkg::CMD_QUERY, 10'h155);
		send_cmd(btpa_pkg::CMD_ALLOC, 10'h155);
		send_cmd(btpa_pkg::CMD_ALLOC, 10'd0);
		send_cmd(btpa_pkg::CMD_ALLOC, 10'd0);
		send_cmd(btpa_pkg::CMD_FREE,  10'd2);
		send_cmd(btpa_pkg::CMD_QUERY, 10'd2);
		send_cmd(btpa_pkg::CMD_QUERY, 10'd3);

		// fill the tree until allocate keeps failing on an empty root
		n = 0;
		while (sb.alloc_fails < 4 && n < 1600) begin
			send_random(98, 1);
			n++;
		end

		wait_drained();

		// give many pages back
		for (n = 0; n < 100; n++) send_random(20, 65);

		wait_drained();

		// mixed traffic with an unbroken back-to-back stretch
		for (n = 0; n < 100; n++) begin
			idle_on = !(n >= 20 && n < 80);
			send_random(45, 35);
		end
		idle_on = 1'b1;

		start <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (sb.pending() != 0 && guard < 200) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d replies never arrived", $time, sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/btpa_pkg.sv
rtl/core/btpa_ram.sv
rtl/core/btpa_step.sv
rtl/core/bit_tree_page_allocator.sv
dv/tb_bit_tree_page_allocator.sv
